// ===== hw/rtl/smc_pkg.sv =====
package smc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CW = 34;
  localparam int TW = 20;
  localparam int TRIG_LAT = CORDIC_STEPS + 1;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  localparam logic signed [CW-1:0] ATAN_TURN [CORDIC_STEPS] = '{
    34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
    34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
    34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
    34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D
  };

  typedef logic signed [31:0] word_t;
  typedef logic signed [TW-1:0] trig_val_t;

  typedef struct packed {
    trig_val_t c;
    trig_val_t s;
  } trig_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] size;
  } side_t;

  typedef enum logic [2:0] {
    REG_PROJ_SCALE_X  = 3'd0,
    REG_PROJ_SCALE_Y  = 3'd1,
    REG_PROJ_SCALE_Z  = 3'd2,
    REG_PROJ_OFFSET_X = 3'd3,
    REG_PROJ_OFFSET_Y = 3'd4,
    REG_PROJ_OFFSET_Z = 3'd5
  } reg_idx_t;

  localparam logic [1:0] COL_LAST = 2'd3;

  function automatic word_t sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -65'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic word_t rnd_sat16(input logic signed [63:0] v);
    logic signed [64:0] t;
    t = (65'(v) + 65'sd32768) >>> 16;
    return sat32(t);
  endfunction

endpackage

// ===== hw/rtl/sprite_model_projection_matrix_top.sv =====
// Sprite model-projection matrix unit. An item is taken when start is high and busy is low;
// busy then stays high while its countdown runs, so no new sprite is taken until busy falls.
// Each sprite returns four words, columns 0 to 3, on consecutive cycles with out_valid high,
// out_last marking column 3; the first word reaches the outputs through the 16-cell CORDIC
// chain, one rounding stage, five matrix stages and the column register. The receiver cannot
// stall the output. Projection registers are written through the cfg port, one per cycle,
// and should only be written while no sprite is in flight.
module sprite_model_projection_matrix_top import smc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [15:0] in_angle_x,
  input  logic [15:0] in_angle_y,
  input  logic [15:0] in_angle_z,
  input  logic [31:0] in_size_x,
  input  logic [31:0] in_size_y,
  input  logic [31:0] in_size_z,
  output logic        out_valid,
  output logic [1:0]  out_column,
  output logic [31:0] out_row_zero,
  output logic [31:0] out_row_one,
  output logic [31:0] out_row_two,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  word_t      ps_r [3];
  word_t      po_r [3];
  logic [1:0] cd_r;
  logic       accept;

  assign accept    = start && !busy;
  assign busy      = cd_r != 2'd0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r[0] <= 32'sd8192;
      ps_r[1] <= -32'sd14564;
      ps_r[2] <= 32'sd655;
      po_r[0] <= 32'sd0;
      po_r[1] <= 32'sd0;
      po_r[2] <= -32'sd7;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROJ_SCALE_X:  ps_r[0] <= cfg_data;
        REG_PROJ_SCALE_Y:  ps_r[1] <= cfg_data;
        REG_PROJ_SCALE_Z:  ps_r[2] <= cfg_data;
        REG_PROJ_OFFSET_X: po_r[0] <= cfg_data;
        REG_PROJ_OFFSET_Y: po_r[1] <= cfg_data;
        REG_PROJ_OFFSET_Z: po_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r <= '0;
    end else if (accept) begin
      cd_r <= 2'd3;
    end else if (busy) begin
      cd_r <= cd_r - 2'd1;
    end
  end

  // position and scale ride alongside the cordic chain
  side_t              side_r [TRIG_LAT];
  logic [TRIG_LAT-1:0] vld_r;
  side_t              side_in;

  assign side_in.pos  = {in_pos_z, in_pos_y, in_pos_x};
  assign side_in.size = {in_size_z, in_size_y, in_size_x};

  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int i = 1; i < TRIG_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TRIG_LAT-2:0], accept};
    end
  end

  trig_t t1, t2, t3;

  smc_trig u_trig_y (.clk(clk), .angle(in_angle_y), .cs(t1));
  smc_trig u_trig_x (.clk(clk), .angle(in_angle_x), .cs(t2));
  smc_trig u_trig_z (.clk(clk), .angle(in_angle_z), .cs(t3));

  logic  mat_vld;
  word_t cols [4][3];

  smc_matrix u_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_r[TRIG_LAT-1]),
    .t1     (t1),
    .t2     (t2),
    .t3     (t3),
    .side_i (side_r[TRIG_LAT-1]),
    .ps     (ps_r),
    .po     (po_r),
    .vld_o  (mat_vld),
    .col_o  (cols)
  );

  // column serializer
  word_t      hold_r [4][3];
  logic [1:0] col_r;
  logic       act_r;

  always_ff @(posedge clk) begin
    if (mat_vld) begin
      hold_r <= cols;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      col_r <= '0;
    end else if (mat_vld) begin
      act_r <= 1'b1;
      col_r <= '0;
    end else if (act_r) begin
      col_r <= col_r + 2'd1;
      if (col_r == COL_LAST) begin
        act_r <= 1'b0;
      end
    end
  end

  assign out_valid    = act_r;
  assign out_column   = col_r;
  assign out_row_zero = hold_r[col_r][0];
  assign out_row_one  = hold_r[col_r][1];
  assign out_row_two  = hold_r[col_r][2];
  assign out_last     = act_r && (col_r == COL_LAST);

endmodule

// ===== hw/rtl/smc_cordic_cell.sv =====
module smc_cordic_cell import smc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  input  logic [1:0]           quad_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [CW-1:0] z_o,
  output logic [1:0]           quad_o
);

  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_nxt, y_nxt, z_nxt;

  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_comb begin
    if (z_i >= 0) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN_TURN[STEP];
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN_TURN[STEP];
    end
  end

  always_ff @(posedge clk) begin
    x_o    <= x_nxt;
    y_o    <= y_nxt;
    z_o    <= z_nxt;
    quad_o <= quad_i;
  end

endmodule

// ===== hw/rtl/smc_trig.sv =====
module smc_trig import smc_pkg::*; (
  input  logic        clk,
  input  logic [15:0] angle,
  output trig_t       cs
);

  logic signed [CW-1:0] x [CORDIC_STEPS+1];
  logic signed [CW-1:0] y [CORDIC_STEPS+1];
  logic signed [CW-1:0] z [CORDIC_STEPS+1];
  logic [1:0]           q [CORDIC_STEPS+1];
  logic signed [CW-1:0] xr, yr;
  trig_val_t            c, s;
  trig_t                cs_nxt;

  assign x[0] = CORDIC_GAIN;
  assign y[0] = '0;
  assign z[0] = CW'(angle[13:0]) <<< 16;
  assign q[0] = angle[15:14];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    smc_cordic_cell #(.STEP(i)) u_cell (
      .clk    (clk),
      .x_i    (x[i]),
      .y_i    (y[i]),
      .z_i    (z[i]),
      .quad_i (q[i]),
      .x_o    (x[i+1]),
      .y_o    (y[i+1]),
      .z_o    (z[i+1]),
      .quad_o (q[i+1])
    );
  end

  assign xr = (x[CORDIC_STEPS] + CW'(8192)) >>> 14;
  assign yr = (y[CORDIC_STEPS] + CW'(8192)) >>> 14;
  assign c  = xr[TW-1:0];
  assign s  = yr[TW-1:0];

  always_comb begin
    case (q[CORDIC_STEPS])
      2'd0: begin cs_nxt.c = c;  cs_nxt.s = s;  end
      2'd1: begin cs_nxt.c = -s; cs_nxt.s = c;  end
      2'd2: begin cs_nxt.c = -c; cs_nxt.s = -s; end
      default: begin cs_nxt.c = s; cs_nxt.s = -c; end
    endcase
  end

  always_ff @(posedge clk) begin
    cs <= cs_nxt;
  end

endmodule

// ===== hw/rtl/smc_matrix.sv =====
module smc_matrix import smc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_i,
  input  trig_t       t1,
  input  trig_t       t2,
  input  trig_t       t3,
  input  side_t       side_i,
  input  word_t       ps [3],
  input  word_t       po [3],
  output logic        vld_o,
  output word_t       col_o [4][3]
);

  logic [4:0] vld_r;
  side_t      side1_r, side2_r, side3_r, side4_r;

  // stage 1: pairwise trig products
  logic signed [2*TW-1:0] c1c3_r, s1s2_r, c2s3_r, c1s2_r, c3s1_r;
  logic signed [2*TW-1:0] c1s3_r, c2c3_r, s1s3_r, c2s1_r, c1c2_r;
  trig_val_t              s2_r, s3_r;

  always_ff @(posedge clk) begin
    c1c3_r  <= t1.c * t3.c;
    s1s2_r  <= t1.s * t2.s;
    c2s3_r  <= t2.c * t3.s;
    c1s2_r  <= t1.c * t2.s;
    c3s1_r  <= t3.c * t1.s;
    c1s3_r  <= t1.c * t3.s;
    c2c3_r  <= t2.c * t3.c;
    s1s3_r  <= t1.s * t3.s;
    c2s1_r  <= t2.c * t1.s;
    c1c2_r  <= t1.c * t2.c;
    s2_r    <= t2.s;
    s3_r    <= t3.s;
    side1_r <= side_i;
  end

  // stage 2: rotation entries, 48 fraction bits
  logic signed [3*TW-1:0] t00, t02, t10, t12;
  logic signed [61:0]     rot_nxt [9];
  logic signed [61:0]     rot_r   [9];

  assign t00 = s1s2_r * s3_r;
  assign t02 = c1s2_r * s3_r;
  assign t10 = c3s1_r * s2_r;
  assign t12 = c1c3_r * s2_r;

  always_comb begin
    rot_nxt[0] = (62'(c1c3_r) <<< 16) + 62'(t00);
    rot_nxt[1] = 62'(c2s3_r) <<< 16;
    rot_nxt[2] = 62'(t02) - (62'(c3s1_r) <<< 16);
    rot_nxt[3] = 62'(t10) - (62'(c1s3_r) <<< 16);
    rot_nxt[4] = 62'(c2c3_r) <<< 16;
    rot_nxt[5] = 62'(t12) + (62'(s1s3_r) <<< 16);
    rot_nxt[6] = 62'(c2s1_r) <<< 16;
    rot_nxt[7] = -(62'(s2_r) <<< 32);
    rot_nxt[8] = 62'(c1c2_r) <<< 16;
  end

  always_ff @(posedge clk) begin
    rot_r   <= rot_nxt;
    side2_r <= side1_r;
  end

  // stage 3: round to Q4.16
  trig_val_t          rq_r [9];
  logic signed [61:0] rr   [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      rr[k] = (rot_r[k] + 62'sd2147483648) >>> 32;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      rq_r[k] <= rr[k][TW-1:0];
    end
    side3_r <= side2_r;
  end

  // stage 4: scale into model entries
  logic signed [TW+31:0] pm [9];
  word_t                 m_r [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pm[k] = $signed(side3_r.size[k/3]) * rq_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      m_r[k] <= rnd_sat16(64'(pm[k]));
    end
    side4_r <= side3_r;
  end

  // stage 5: projection
  logic signed [63:0] pv [9];
  logic signed [63:0] pt [3];
  logic signed [64:0] pr [3];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      pv[k] = ps[k%3] * m_r[k];
    end
    for (int r = 0; r < 3; r++) begin
      pt[r] = ps[r] * $signed(side4_r.pos[r]);
      pr[r] = ((65'(pt[r]) + 65'sd32768) >>> 16) + 65'(po[r]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      col_o[k/3][k%3] <= rnd_sat16(pv[k]);
    end
    for (int r = 0; r < 3; r++) begin
      col_o[3][r] <= sat32(pr[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], vld_i};
    end
  end

  assign vld_o = vld_r[4];

endmodule

// ===== hw/rtl/smc_checker.sv =====
module smc_checker import smc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_column,
  input logic       out_last
);

  a_last_on_col3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_column == COL_LAST)))
    else $error("last flag does not match column");

  a_col_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_column != COL_LAST) |=>
      (out_valid && out_column == $past(out_column) + 2'd1))
    else $error("column sequence broken");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after word taken");

  a_no_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_last)
    else $error("last without valid");

endmodule

bind sprite_model_projection_matrix_top smc_checker u_smc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_column (out_column),
  .out_last   (out_last)
);

// ===== tb/sprite_model_projection_matrix_top_tb.sv =====
class matrix_scoreboard;
  typedef struct {
    logic [1:0]  column;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic        last;
  } column_word_t;

  column_word_t pending[$];
  int unsigned errors;
  int unsigned reported;
  longint proj_scale[3];
  longint proj_offset[3];
  longint atan_tab[16];

  function new();
    atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                 64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                 64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    errors = 0;
    reported = 0;
    set_defaults();
  endfunction

  function void set_defaults();
    proj_scale = '{8192, -14564, 655};
    proj_offset = '{0, 0, -7};
  endfunction

  function void write_reg(smc_pkg::reg_idx_t idx, logic [31:0] data);
    longint v;
    v = longint'($signed(data));
    if (idx < smc_pkg::REG_PROJ_OFFSET_X) proj_scale[idx] = v;
    else if (idx <= smc_pkg::REG_PROJ_OFFSET_Z)
      proj_offset[idx - smc_pkg::REG_PROJ_OFFSET_X] = v;
  endfunction

  // arithmetic shift is floor division for signed longint
  function longint round_off(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void sincos(logic [15:0] a, output longint co, output longint si);
    longint x, y, z, dx, dy, c, s;
    x = 64'h26DD3B6A;
    y = 0;
    z = longint'(a[13:0]) <<< 16;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = round_off(x, 14);
    s = round_off(y, 14);
    case (a[15:14])
      2'd0: begin co = c; si = s; end
      2'd1: begin co = -s; si = c; end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  function void note_sprite(logic [31:0] pos[3], logic [15:0] ang[3], logic [31:0] size[3]);
    longint c1, s1, c2, s2, c3, s3, one, rq, m;
    longint rot[3][3];
    longint v[3];
    column_word_t w;
    one = 65536;
    sincos(ang[1], c1, s1);
    sincos(ang[0], c2, s2);
    sincos(ang[2], c3, s3);
    rot[0][0] = c1 * c3 * one + s1 * s2 * s3;
    rot[0][1] = c2 * s3 * one;
    rot[0][2] = c1 * s2 * s3 - c3 * s1 * one;
    rot[1][0] = c3 * s1 * s2 - c1 * s3 * one;
    rot[1][1] = c2 * c3 * one;
    rot[1][2] = c1 * c3 * s2 + s1 * s3 * one;
    rot[2][0] = c2 * s1 * one;
    rot[2][1] = -s2 * one * one;
    rot[2][2] = c1 * c2 * one;
    for (int j = 0; j < 4; j++) begin
      for (int r = 0; r < 3; r++) begin
        if (j < 3) begin
          rq = round_off(rot[j][r], 32);
          m = clamp32(round_off(longint'($signed(size[j])) * rq, 16));
          v[r] = clamp32(round_off(proj_scale[r] * m, 16));
        end else begin
          v[r] = clamp32(round_off(proj_scale[r] * longint'($signed(pos[r])), 16)
                         + proj_offset[r]);
        end
      end
      w.column = j[1:0];
      w.r0 = v[0][31:0];
      w.r1 = v[1][31:0];
      w.r2 = v[2][31:0];
      w.last = (j == 3);
      pending = {pending, w};
    end
  endfunction

  function void check_word(logic [1:0] col, logic [31:0] r0, logic [31:0] r1,
                           logic [31:0] r2, logic last);
    column_word_t e;
    if (pending.size() == 0) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("unexpected word col=%0d %h %h %h last=%b", col, r0, r1, r2, last);
      end
      return;
    end
    e = pending.pop_front();
    if (e.column !== col || e.r0 !== r0 || e.r1 !== r1 || e.r2 !== r2 || e.last !== last) begin
      errors++;
      if (reported < 10) begin
        reported++;
        $display("mismatch exp col=%0d %h %h %h last=%b got col=%0d %h %h %h last=%b",
                 e.column, e.r0, e.r1, e.r2, e.last, col, r0, r1, r2, last);
      end
    end
  endfunction
endclass

module sprite_model_projection_matrix_top_tb;
  import smc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic [15:0] in_angle_x, in_angle_y, in_angle_z;
  logic [31:0] in_size_x, in_size_y, in_size_z;
  logic        out_valid;
  logic [1:0]  out_column;
  logic [31:0] out_row_zero, out_row_one, out_row_two;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  matrix_scoreboard board;
  bit          calm;

  sprite_model_projection_matrix_top u_dut (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      board.check_word(out_column, out_row_zero, out_row_one, out_row_two, out_last);
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h00010000;
      3: return 32'($signed($urandom_range(0, 262143)) - 131072);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'(($urandom_range(0, 3)) << 14);
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // start stays high after a take; idling or drain lowers it
  task automatic send_sprite(logic [31:0] pos[3], logic [15:0] ang[3], logic [31:0] size[3]);
    if (!calm) begin
      while ($urandom_range(0, 99) < 15) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_pos_x <= pos[0];  in_pos_y <= pos[1];  in_pos_z <= pos[2];
    in_angle_x <= ang[0]; in_angle_y <= ang[1]; in_angle_z <= ang[2];
    in_size_x <= size[0]; in_size_y <= size[1]; in_size_z <= size[2];
    do @(posedge clk); while (busy);
    board.note_sprite(pos, ang, size);
  endtask

  task automatic send_random();
    logic [31:0] pos[3];
    logic [15:0] ang[3];
    logic [31:0] size[3];
    for (int i = 0; i < 3; i++) begin
      pos[i] = pick_word();
      ang[i] = pick_angle();
      size[i] = pick_word();
    end
    send_sprite(pos, ang, size);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  task automatic load_regs(logic [31:0] v[6]);
    for (int i = 0; i < 6; i++) write_reg(reg_idx_t'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] pos[3];
    logic [15:0] ang[3];
    logic [31:0] size[3];
    logic [31:0] regs_set[6];
    board = new();
    calm = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {in_pos_x, in_pos_y, in_pos_z} = '0;
    {in_angle_x, in_angle_y, in_angle_z} = '0;
    {in_size_x, in_size_y, in_size_z} = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset projection, directed corners
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 3; i++) begin
        ang[i] = 16'(k * 8192 + (k == 7 ? 8191 : 0));
        pos[i] = (k[0]) ? 32'h7FFFFFFF : 32'h80000000;
        size[i] = (k[1]) ? 32'h7FFFFFFF : ((k[2]) ? 32'h80000000 : 32'h00010000);
      end
      send_sprite(pos, ang, size);
    end
    pos = '{0, 0, 0}; ang = '{0, 0, 0}; size = '{0, 0, 0};
    send_sprite(pos, ang, size);
    drain();

    // extreme projection settings
    regs_set = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
    load_regs(regs_set);
    for (int k = 0; k < 6; k++) send_random();
    drain();
    regs_set = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
    load_regs(regs_set);
    for (int k = 0; k < 6; k++) send_random();
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      for (int i = 0; i < 6; i++) regs_set[i] = pick_word();
      if (ph == 4) begin
        regs_set = '{32'd8192, -32'sd14564, 32'd655, 32'd0, 32'd0, -32'sd7};
      end
      load_regs(regs_set);
      calm = (ph == 2);
      for (int k = 0; k < 50; k++) begin
        send_random();
        if (k == 25) drain();
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
